// ===== hdl/pnas_pkg.sv =====
// shared types, codes and helpers of the plotter numeric argument scanner
package pnas_pkg;

	// field widths
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned WHOLE_W = 31;
	localparam int unsigned FRAC_W  = 30;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned KIND_W  = 2;

	// default limit on kept fraction digits
	localparam int unsigned MAX_FRACTION_DIGITS_DEF = 9;

	// largest integer part and the overflow test constants derived from it
	localparam logic [WHOLE_W-1:0] WHOLE_LIMIT     = 31'h7fff_ffff;
	localparam logic [WHOLE_W-1:0] WHOLE_LIMIT_DIV = WHOLE_W'(WHOLE_LIMIT / 10);
	localparam logic [3:0]         WHOLE_LIMIT_MOD = 4'(WHOLE_LIMIT % 10);

	// character codes
	localparam logic [CHAR_W-1:0] CH_HT    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0c;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INTEGER  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REAL     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

	// scan phase
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_INT   = 2'd1,
		PH_REAL  = 2'd2,
		PH_ENDED = 2'd3
	} phase_t;

	// character classes
	typedef enum logic [2:0] {
		CC_IGNORE,
		CC_SIGN,
		CC_POINT,
		CC_SEP,
		CC_DIGIT,
		CC_END
	} char_class_t;

	// one result beat
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic               negative;
		logic [WHOLE_W-1:0] whole_part;
		logic [FRAC_W-1:0]  fraction_digits;
		logic [COUNT_W-1:0] fraction_count;
		logic               list_end;
	} result_t;

	// classify one text byte
	function automatic char_class_t classify(input logic [CHAR_W-1:0] ch);
		char_class_t cc;
		unique case (ch) inside
			CH_HT, CH_LF, CH_FF, CH_CR: cc = CC_IGNORE;
			CH_PLUS, CH_MINUS:          cc = CC_SIGN;
			CH_POINT:                   cc = CC_POINT;
			CH_SPACE, CH_COMMA:         cc = CC_SEP;
			[CH_ZERO:CH_NINE]:          cc = CC_DIGIT;
			default:                    cc = CC_END;
		endcase
		return cc;
	endfunction

endpackage

// ===== hdl/pnas_in_stage.sv =====
// input register for text bytes
module pnas_in_stage
	import pnas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] in_char,
	output logic              valid_s1,
	output logic [CHAR_W-1:0] char_s1,
	input  logic              take
);

	// room when empty or when the held byte leaves this cycle
	assign in_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
		end
	end

endmodule

// ===== hdl/pnas_scan_core.sv =====
// scanner state and per-byte number building
module pnas_scan_core
	import pnas_pkg::*;
#(
	parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [CHAR_W-1:0] char_s1,
	output logic              res_valid,
	output result_t           res
);

	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRACTION_DIGITS);

	phase_t             phase_q, phase_d;
	logic               minus_q, minus_d;
	logic [WHOLE_W-1:0] whole_q, whole_d;
	logic [FRAC_W-1:0]  frac_q, frac_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;

	char_class_t        cc;
	logic [3:0]         digit;
	logic               pending;
	logic               overflow;
	logic [WHOLE_W+3:0] whole_x10;
	logic [FRAC_W+3:0]  frac_x10;
	result_t            pend_res;

	// byte decode and arithmetic
	assign cc        = classify(char_s1);
	assign digit     = 4'(char_s1 - CH_ZERO);
	assign pending   = (phase_q == PH_INT) || (phase_q == PH_REAL);
	assign overflow  = (whole_q > WHOLE_LIMIT_DIV) ||
			((whole_q == WHOLE_LIMIT_DIV) && (digit > WHOLE_LIMIT_MOD));
	assign whole_x10 = {whole_q, 3'b000} + {2'b00, whole_q, 1'b0} + (WHOLE_W+4)'(digit);
	assign frac_x10  = {frac_q, 3'b000} + {2'b00, frac_q, 1'b0} + (FRAC_W+4)'(digit);

	// pending number as a result
	always_comb begin
		pend_res = '0;
		if (phase_q == PH_INT) begin
			pend_res.kind       = KIND_INTEGER;
			pend_res.negative   = minus_q;
			pend_res.whole_part = whole_q;
		end else if (phase_q == PH_REAL) begin
			pend_res.kind            = KIND_REAL;
			pend_res.negative        = minus_q;
			pend_res.whole_part      = whole_q;
			pend_res.fraction_digits = frac_q;
			pend_res.fraction_count  = cnt_q;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		minus_d = minus_q;
		whole_d = whole_q;
		frac_d  = frac_q;
		cnt_d   = cnt_q;
		if (phase_q != PH_ENDED) begin
			unique case (cc)
				CC_IGNORE: begin
				end
				CC_SIGN: begin
					minus_d = (char_s1 == CH_MINUS);
					whole_d = '0;
					frac_d  = '0;
					cnt_d   = '0;
					phase_d = PH_INT;
				end
				CC_POINT: begin
					if (phase_q != PH_INT) begin
						minus_d = 1'b0;
						whole_d = '0;
					end
					frac_d  = '0;
					cnt_d   = '0;
					phase_d = PH_REAL;
				end
				CC_SEP: begin
					if (pending) begin
						minus_d = 1'b0;
						whole_d = '0;
						frac_d  = '0;
						cnt_d   = '0;
						phase_d = PH_IDLE;
					end
				end
				CC_DIGIT: begin
					if (phase_q == PH_IDLE) begin
						minus_d = 1'b0;
						whole_d = WHOLE_W'(digit);
						frac_d  = '0;
						cnt_d   = '0;
						phase_d = PH_INT;
					end else if (phase_q == PH_INT) begin
						if (overflow) begin
							minus_d = 1'b0;
							whole_d = '0;
							frac_d  = '0;
							cnt_d   = '0;
							phase_d = PH_ENDED;
						end else begin
							whole_d = whole_x10[WHOLE_W-1:0];
						end
					end else if (cnt_q < MAX_CNT) begin
						frac_d = frac_x10[FRAC_W-1:0];
						cnt_d  = cnt_q + 1'b1;
					end
				end
				default: begin
					minus_d = 1'b0;
					whole_d = '0;
					frac_d  = '0;
					cnt_d   = '0;
					phase_d = PH_ENDED;
				end
			endcase
		end
	end

	// result for this byte
	always_comb begin
		res_valid = 1'b0;
		res       = pend_res;
		if (phase_q != PH_ENDED) begin
			unique case (cc)
				CC_IGNORE: begin
				end
				CC_SIGN: begin
					res_valid = pending;
				end
				CC_POINT: begin
					res_valid = (phase_q == PH_REAL);
				end
				CC_SEP: begin
					res_valid = pending;
				end
				CC_DIGIT: begin
					if ((phase_q == PH_INT) && overflow) begin
						res_valid    = 1'b1;
						res          = '0;
						res.kind     = KIND_OVERFLOW;
						res.negative = minus_q;
						res.list_end = 1'b1;
					end
				end
				default: begin
					res_valid    = 1'b1;
					res.list_end = 1'b1;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			minus_q <= 1'b0;
			whole_q <= '0;
			frac_q  <= '0;
			cnt_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			minus_q <= minus_d;
			whole_q <= whole_d;
			frac_q  <= frac_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== hdl/pnas_out_buf.sv =====
// two-entry output register with skid slot
module pnas_out_buf
	import pnas_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_res,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    head_v_q, tail_v_q;
	result_t head_q, tail_q;
	logic    pop;

	assign space     = !tail_v_q;
	assign out_valid = head_v_q;
	assign out_res   = head_q;
	assign pop       = head_v_q && out_ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else if (pop) begin
			head_v_q <= tail_v_q || push;
			tail_v_q <= tail_v_q && push;
		end else if (push) begin
			head_v_q <= 1'b1;
			tail_v_q <= head_v_q;
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= tail_v_q ? tail_q : push_res;
			if (push) begin
				tail_q <= push_res;
			end
		end else if (push) begin
			if (head_v_q) begin
				tail_q <= push_res;
			end else begin
				head_q <= push_res;
			end
		end
	end

endmodule

// ===== hdl/plotter_numeric_argument_scanner.sv =====
// top level of the plotter numeric argument scanner
// Takes one byte of argument text per beat and returns each finished number as one beat:
// kind on tuser, list end on tlast, the value fields on tdata. A byte is accepted in every
// cycle while the output side keeps up; an input beat passes the input register, then the
// scanner's single pass of multiply-by-ten, compare and select, then the result register.
// After a list end or an integer overflow every byte is consumed without result until reset.
module plotter_numeric_argument_scanner
	import pnas_pkg::*;
#(
	parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // character
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // negative, whole_part, fraction_digits, fraction_count, zeros
	output logic        m_tlast,  // list_end
	output logic [1:0]  m_tuser   // kind
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              space;
	logic              fire;
	logic              res_valid;
	result_t           res;
	result_t           out_res;

	assign fire = valid_s1 && space;

	pnas_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.take     (fire)
	);

	pnas_scan_core #(
		.MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_s1   (char_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	pnas_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && res_valid),
		.push_res  (res),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// result beat packing
	assign m_tdata = {6'b000000, out_res.fraction_count, out_res.fraction_digits,
			out_res.whole_part, out_res.negative};
	assign m_tlast = out_res.list_end;
	assign m_tuser = out_res.kind;

endmodule
